@@ rtl/core/cbba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_pkg
// shared types and constants of the contiguous block bitmap allocator
// ----------------------------------------------------------------------------
package cbba_pkg;

    // bitmap word geometry
    localparam int WORD_W  = 16;
    localparam int WORD_LG = 4;

    // field widths
    localparam int MODE_W  = 1;
    localparam int FIRST_W = 10;
    localparam int COUNT_W = 11;
    localparam int START_W = 10;
    localparam int CFG_W   = 11;
    localparam int RUN_W   = COUNT_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // request kinds
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_MODIFY,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic decide;
        logic scan;
        logic modify;
        logic respond;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_release;
        logic alloc_skip;
        logic rel_empty;
        logic scan_hit;
        logic scan_fail;
        logic mod_done;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/contiguous_block_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// flow: an allocate reads bitmap words (16 blocks each) until a run fits, then marks the
//   words the run covers; a failed allocate only scans, a release clears the words of its
//   span; a zero length or empty range skips the map; a full result register stalls the reply
// requests: one at a time, the next taken in the cycle after the result is loaded;
//   the word scan sets the rate, up to 64 words for 1024 managed blocks plus the marking pass
// reset: synchronous active low; a clearing pass over ceil(MAX_BLOCKS/16) words frees the map
// ----------------------------------------------------------------------------
// contiguous_block_bitmap_allocator
// first fit allocator of contiguous block runs over a used/free bitmap
// ----------------------------------------------------------------------------
module contiguous_block_bitmap_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // first_block[9:0], block_count[20:10], zero pad
    input  logic        s_tuser,   // mode: 0 allocate, 1 release
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // found_start[9:0], zero pad
    output logic        m_tuser,   // ok
    // block count register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // managed block count
);

    cbba_pkg::cmd_t                cmd;
    cbba_pkg::sts_t                sts;
    logic                          in_ready;
    logic                          out_ok;
    logic [cbba_pkg::START_W-1:0]  out_start;

    // request field split
    logic [cbba_pkg::FIRST_W-1:0]  req_first;
    logic [cbba_pkg::COUNT_W-1:0]  req_count;

    assign req_first = s_tdata[9:0];
    assign req_count = s_tdata[20:10];

    // sequencer: clearing pass, decode, scan, mark or release, respond
    cbba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // bitmap ram, scanner and result register
    cbba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_mode   (s_tuser),
        .in_first  (req_first),
        .in_count  (req_count),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_ok    (out_ok),
        .out_start (out_start)
    );

    // requests are taken in idle even while a result waits in the output register
    assign s_tready  = in_ready;
    // user rule, not enforced: register writes only while idle; the channel is always open
    assign cfg_ready = 1'b1;

    assign m_tdata = {{(16 - cbba_pkg::START_W){1'b0}}, out_start};
    assign m_tuser = out_ok;

endmodule

@@ rtl/core/cbba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cbba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/cbba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_ctrl
// request sequencer: clearing pass, decode, scan, modify, respond
// ----------------------------------------------------------------------------
module cbba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  cbba_pkg::sts_t sts,
    output logic          in_ready,
    output cbba_pkg::cmd_t cmd
);

    cbba_pkg::state_t state_reg;
    cbba_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbba_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbba_pkg::ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = cbba_pkg::ST_IDLE;
                end
            end
            cbba_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = cbba_pkg::ST_DECIDE;
                end
            end
            cbba_pkg::ST_DECIDE: begin
                if (sts.is_release) begin
                    state_next = sts.rel_empty ? cbba_pkg::ST_RESPOND : cbba_pkg::ST_MODIFY;
                end else begin
                    state_next = sts.alloc_skip ? cbba_pkg::ST_RESPOND : cbba_pkg::ST_SCAN;
                end
            end
            cbba_pkg::ST_SCAN: begin
                if (sts.scan_hit) begin
                    state_next = cbba_pkg::ST_MODIFY;
                end else if (sts.scan_fail) begin
                    state_next = cbba_pkg::ST_RESPOND;
                end
            end
            cbba_pkg::ST_MODIFY: begin
                if (sts.mod_done) begin
                    state_next = cbba_pkg::ST_RESPOND;
                end
            end
            cbba_pkg::ST_RESPOND: begin
                if (sts.out_free) begin
                    state_next = cbba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            cbba_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            cbba_pkg::ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            cbba_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            cbba_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            cbba_pkg::ST_MODIFY: begin
                cmd.modify = 1'b1;
            end
            cbba_pkg::ST_RESPOND: begin
                cmd.respond = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/cbba_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_dpath
// bitmap ram, word scanner with run carry, range modify and result register
// ----------------------------------------------------------------------------
module cbba_dpath #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cbba_pkg::cmd_t                cmd,
    output cbba_pkg::sts_t                sts,
    input  logic                          in_mode,
    input  logic [cbba_pkg::FIRST_W-1:0]  in_first,
    input  logic [cbba_pkg::COUNT_W-1:0]  in_count,
    input  logic                          cfg_valid,
    input  logic [cbba_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_ok,
    output logic [cbba_pkg::START_W-1:0]  out_start
);

    localparam int WW    = cbba_pkg::WORD_W;
    localparam int WL    = cbba_pkg::WORD_LG;
    localparam int WORDS = (MAX_BLOCKS + WW - 1) / WW;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W = AW + WL;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int M1_W  = (POS_W > cbba_pkg::CFG_W) ? POS_W : cbba_pkg::CFG_W;
    localparam int CMP_W = ((M1_W > CNT_W) ? M1_W : CNT_W) + 1;
    localparam int RW    = cbba_pkg::RUN_W;
    localparam int CW    = cbba_pkg::COUNT_W;

    logic [cbba_pkg::CFG_W-1:0]   cfg_reg;
    logic [AW-1:0]                clr_ptr_reg;
    logic [AW-1:0]                rd_ptr_reg;
    logic [AW-1:0]                pend_addr_reg;
    logic                         pend_valid_reg;
    logic                         mode_reg;
    logic [cbba_pkg::FIRST_W-1:0] first_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                carry_reg;
    logic [CMP_W-1:0]             total_reg;
    logic [CMP_W-1:0]             lo_reg;
    logic [CMP_W-1:0]             hi_reg;
    logic                         ok_reg;
    logic [cbba_pkg::START_W-1:0] start_reg;
    logic                         out_valid_reg;
    logic                         out_ok_reg;
    logic [cbba_pkg::START_W-1:0] out_start_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic [WW-1:0]     ram_rdata;

    logic [CMP_W-1:0]  total_w;
    logic [CMP_W-1:0]  base_w;
    logic [WW-1:0]     free_w;
    logic [WW-1:0]     in_rng_w;
    logic [WW-1:0]     hit_vec_w;
    logic [RW-1:0]     run_w [WW];
    logic [WL-1:0]     hit_idx_w;
    logic [CMP_W-1:0]  start_w;
    logic [CW-1:0]     carry_next_w;
    logic [CMP_W-1:0]  last_word_w;
    logic [CMP_W-1:0]  mod_last_w;
    logic [CMP_W-1:0]  rel_sum_w;
    logic [CMP_W-1:0]  rel_hi_w;
    logic [CMP_W-1:0]  rel_word_w;
    logic [WW-1:0]     mod_word_w;

    cbba_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    // managed block count, saturated to the map size
    assign total_w = (CMP_W'(cfg_reg) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                             : CMP_W'(cfg_reg);

    assign base_w = CMP_W'({pend_addr_reg, {WL{1'b0}}});

    // per-bit free flags and modify window
    always_comb begin
        logic [CMP_W-1:0] pos;
        for (int j = 0; j < WW; j++) begin
            pos         = base_w + CMP_W'(j);
            free_w[j]   = !ram_rdata[j] && (pos < total_reg);
            in_rng_w[j] = (pos >= lo_reg) && (pos < hi_reg);
        end
    end

    // free run length ending at each bit
    always_comb begin
        logic          any_used;
        logic [WL-1:0] last_used;
        for (int j = 0; j < WW; j++) begin
            any_used  = 1'b0;
            last_used = '0;
            for (int i = 0; i < WW; i++) begin
                if (i <= j && !free_w[i]) begin
                    any_used  = 1'b1;
                    last_used = WL'(i);
                end
            end
            run_w[j]     = any_used ? RW'(WL'(j) - last_used)
                                    : RW'(carry_reg) + RW'(j + 1);
            hit_vec_w[j] = run_w[j] >= RW'(count_reg);
        end
    end

    always_comb begin
        hit_idx_w = '0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (hit_vec_w[j]) begin
                hit_idx_w = WL'(j);
            end
        end
    end

    assign start_w      = base_w + CMP_W'(hit_idx_w) + CMP_W'(1) - CMP_W'(count_reg);
    assign carry_next_w = run_w[WW-1][CW-1:0];
    assign last_word_w  = (total_reg - CMP_W'(1)) >> WL;
    assign mod_last_w   = (hi_reg - CMP_W'(1)) >> WL;
    assign rel_sum_w    = CMP_W'(first_reg) + CMP_W'(count_reg);
    assign rel_hi_w     = (rel_sum_w < total_reg) ? rel_sum_w : total_reg;
    assign rel_word_w   = CMP_W'(first_reg) >> WL;
    assign mod_word_w   = (mode_reg == cbba_pkg::MODE_ALLOC) ? (ram_rdata | in_rng_w)
                                                              : (ram_rdata & ~in_rng_w);

    assign ram_we    = cmd.clear || (cmd.modify && pend_valid_reg);
    assign ram_waddr = cmd.clear ? clr_ptr_reg : pend_addr_reg;
    assign ram_wdata = cmd.clear ? '0 : mod_word_w;

    always_comb begin
        sts            = '0;
        sts.clear_done = clr_ptr_reg == AW'(WORDS - 1);
        sts.is_release = mode_reg == cbba_pkg::MODE_RELEASE;
        sts.alloc_skip = (count_reg == '0) || (total_reg == '0);
        sts.rel_empty  = rel_hi_w <= CMP_W'(first_reg);
        sts.scan_hit   = pend_valid_reg && (|hit_vec_w);
        sts.scan_fail  = pend_valid_reg && !(|hit_vec_w)
                         && (CMP_W'(pend_addr_reg) == last_word_w);
        sts.mod_done   = pend_valid_reg && (CMP_W'(pend_addr_reg) == mod_last_w);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= cbba_pkg::CFG_RESET;
            clr_ptr_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            if (cmd.clear) begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end
            if (cmd.respond) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept || cmd.decide) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.scan) begin
                pend_valid_reg <= !sts.scan_hit;
            end else if (cmd.modify) begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg   <= in_mode;
            first_reg  <= in_first;
            count_reg  <= in_count;
            total_reg  <= total_w;
            ok_reg     <= 1'b0;
            start_reg  <= '0;
            rd_ptr_reg <= '0;
            carry_reg  <= '0;
        end
        if (cmd.decide && mode_reg == cbba_pkg::MODE_RELEASE) begin
            lo_reg     <= CMP_W'(first_reg);
            hi_reg     <= rel_hi_w;
            ok_reg     <= 1'b1;
            rd_ptr_reg <= rel_word_w[AW-1:0];
        end
        if (cmd.scan) begin
            if (sts.scan_hit) begin
                lo_reg     <= start_w;
                hi_reg     <= start_w + CMP_W'(count_reg);
                ok_reg     <= 1'b1;
                start_reg  <= start_w[cbba_pkg::START_W-1:0];
                rd_ptr_reg <= start_w[POS_W-1:WL];
            end else begin
                rd_ptr_reg    <= rd_ptr_reg + AW'(1);
                pend_addr_reg <= rd_ptr_reg;
                if (pend_valid_reg) begin
                    carry_reg <= carry_next_w;
                end
            end
        end
        if (cmd.modify) begin
            rd_ptr_reg    <= rd_ptr_reg + AW'(1);
            pend_addr_reg <= rd_ptr_reg;
        end
        if (cmd.respond) begin
            out_ok_reg    <= ok_reg;
            out_start_reg <= start_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_start = out_start_reg;

`ifndef SYNTHESIS
    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && sts.scan_hit) |-> ((start_w + CMP_W'(count_reg)) <= total_reg))
        else $error("allocated run runs past the managed blocks");

    a_mod_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.modify && pend_valid_reg) |->
            ((CMP_W'(pend_addr_reg) <= mod_last_w) && (CMP_W'(pend_addr_reg) >= (lo_reg >> WL))))
        else $error("bitmap write outside the modify window");

    a_respond_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.respond |=> out_valid_reg)
        else $error("response not presented after respond");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !ram_we)
        else $error("bitmap written while taking a request");
`endif

endmodule

@@ tb/tb_contiguous_block_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_bitmap_allocator
// self-checking bench for the first fit contiguous block allocator
//
// requests go in on the s_ stream and results come back on the m_ stream.
// a bitmap predictor in the bench mirrors every accepted request and queues
// the answer it expects; each result is checked against the oldest entry.
// directed tests hit the corner cases, then random traffic runs over several
// block count settings with random gaps on both sides, a long receiver
// hold-off and a stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_contiguous_block_bitmap_allocator;

    localparam int MAX_BLK     = 1024;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYC   = 9;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 16;    // settle time once nothing is pending
    localparam int GAP_PCT     = 23;    // idle chance per cycle on either side

    // one expected answer
    typedef struct packed {
        logic                         ok;
        logic [cbba_pkg::START_W-1:0] start;
    } alloc_result_t;

    // a run the bench believes is currently allocated
    typedef struct {
        int start;
        int len;
    } block_run_t;

    // dut ports, inputs known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // first_block[9:0], block_count[20:10], zero pad
    logic        s_tuser   = 1'b0;   // mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // found_start[9:0], zero pad
    logic        m_tuser;            // ok
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data  = '0;

    // predictor state
    bit                         used_bits [MAX_BLK];
    logic [cbba_pkg::CFG_W-1:0] blocks_cfg = cbba_pkg::CFG_RESET;
    alloc_result_t              pending_results [$];
    block_run_t                 live_runs [$];

    int  mismatch_count = 0;
    int  idle_cycles    = 0;

    // knobs shared between the test sequence and the bus processes
    bit  sender_gaps  = 1'b1;
    bit  steady_ready = 1'b0;
    int  hold_trig    = 0;
    int  hold_ack     = 0;
    int  stall_left   = 0;

    contiguous_block_bitmap_allocator #(
        .MAX_BLOCKS(MAX_BLK)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // predictor: first fit over the bench's own bitmap
    // ------------------------------------------------------------------------
    function automatic alloc_result_t predict_request(input logic mode,
            input logic [cbba_pkg::FIRST_W-1:0] first_blk,
            input logic [cbba_pkg::COUNT_W-1:0] count);
        alloc_result_t res;
        int managed;
        int run_start;
        int run_len;
        int idx;
        bit hit;
        res       = '0;
        run_start = 0;
        run_len   = 0;
        hit       = 1'b0;
        // register values above the bitmap size saturate
        managed   = (int'(blocks_cfg) > MAX_BLK) ? MAX_BLK : int'(blocks_cfg);
        if (mode == cbba_pkg::MODE_ALLOC) begin
            // a zero length allocate fails without touching the map
            if (count != 0) begin
                for (idx = 0; idx < managed && !hit; idx++) begin
                    if (!used_bits[idx]) begin
                        if (run_len == 0) run_start = idx;
                        run_len++;
                        if (run_len == int'(count)) hit = 1'b1;
                    end else begin
                        run_len = 0;
                    end
                end
                if (hit) begin
                    for (idx = run_start; idx < run_start + int'(count); idx++)
                        used_bits[idx] = 1'b1;
                    res.ok    = 1'b1;
                    res.start = run_start[cbba_pkg::START_W-1:0];
                    live_runs.push_back('{run_start, int'(count)});
                end
            end
        end else begin
            // blocks at or past the managed count are left alone, answer is still ok
            for (idx = int'(first_blk); idx < int'(first_blk) + int'(count); idx++) begin
                if (idx < managed) used_bits[idx] = 1'b0;
            end
            res.ok = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: random gaps, then hold the request until it is taken.
    // valid stays high after the handshake so back to back requests never
    // lower and raise it in the same step
    // ------------------------------------------------------------------------
    task automatic send_request(input logic mode,
            input logic [cbba_pkg::FIRST_W-1:0] first_blk,
            input logic [cbba_pkg::COUNT_W-1:0] count);
        if (sender_gaps) begin
            while ($urandom_range(99) < GAP_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, count, first_blk};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_request(mode, first_blk, count));
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // block count register write, only called with the block drained
    task automatic write_block_count(input logic [cbba_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        blocks_cfg  = value;
    endtask

    // ------------------------------------------------------------------------
    // random request mix: mostly alloc / release of tracked runs, some noise
    // ------------------------------------------------------------------------
    function automatic logic [cbba_pkg::FIRST_W-1:0] rand_first();
        int v;
        v = $urandom_range(1023);
        return v[cbba_pkg::FIRST_W-1:0];
    endfunction

    function automatic logic [cbba_pkg::COUNT_W-1:0] rand_count(input int lo, input int hi);
        int v;
        v = $urandom_range(hi, lo);
        return v[cbba_pkg::COUNT_W-1:0];
    endfunction

    function automatic logic [cbba_pkg::COUNT_W-1:0] pick_run_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return rand_count(1, 16);
        if (r < 94) return rand_count(17, 96);
        return rand_count(97, 1024);
    endfunction

    task automatic random_request();
        int r;
        int k;
        block_run_t run;
        r = $urandom_range(99);
        if (r < 3) begin
            // wide release anywhere
            send_request(cbba_pkg::MODE_RELEASE, rand_first(), rand_count(0, 1024));
        end else if (r < 9) begin
            // short release at a random spot, may hit free or foreign blocks
            send_request(cbba_pkg::MODE_RELEASE, rand_first(), rand_count(0, 20));
        end else if (r < 13) begin
            // oversized allocate, usually fails
            send_request(cbba_pkg::MODE_ALLOC, rand_first(), rand_count(0, 1024));
        end else if (r < 15) begin
            // zero length request of either kind
            send_request(logic'($urandom_range(1)), rand_first(), '0);
        end else if (live_runs.size() != 0 && (r < 52 || live_runs.size() > 24)) begin
            k   = $urandom_range(live_runs.size() - 1);
            run = live_runs[k];
            live_runs.delete(k);
            send_request(cbba_pkg::MODE_RELEASE, run.start[cbba_pkg::FIRST_W-1:0],
                         run.len[cbba_pkg::COUNT_W-1:0]);
        end else begin
            // first_block is don't care on allocate, keep it random
            send_request(cbba_pkg::MODE_ALLOC, rand_first(), pick_run_len());
        end
    endtask

    // ------------------------------------------------------------------------
    // result receiver: random stalls, optional hold-off, optional steady ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_trig != hold_ack) begin
            hold_ack   = hold_trig;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (steady_ready) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= GAP_PCT);
        end
    end

    // result checker, compares every accepted result with the oldest expectation
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing pending, actual ok %0b start %0d",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.ok) begin
                    mismatch_count++;
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, m_tuser);
                end
                if (m_tdata !== {6'b000000, want.start}) begin
                    mismatch_count++;
                    $display("%0t: found_start expected %0d actual %0d (raw 0x%04h)",
                             $time, want.start, m_tdata[cbba_pkg::START_W-1:0], m_tdata);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // corner cases at the reset block count of 1024, map starts empty
    task automatic test_directed_requests();
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd0);     // zero length allocate fails
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd1);     // lands on block 0
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd1024);  // no run long enough
        send_request(cbba_pkg::MODE_RELEASE, 10'd0,    11'd1);
        send_request(cbba_pkg::MODE_ALLOC,   10'd1023, 11'd1024);  // whole map
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd1);     // full, fails
        send_request(cbba_pkg::MODE_RELEASE, 10'd1023, 11'd1);     // top block
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd1);     // refills the top block
        send_request(cbba_pkg::MODE_RELEASE, 10'd0,    11'd0);     // zero length release
        send_request(cbba_pkg::MODE_RELEASE, 10'd1000, 11'd1024);  // runs past the end
        send_request(cbba_pkg::MODE_RELEASE, 10'd0,    11'd1024);  // everything free
        // first fit: a hole too small is skipped, an exact one is taken
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd5);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd3);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd7);
        send_request(cbba_pkg::MODE_RELEASE, 10'd5,    11'd3);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd4);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0,    11'd3);
        send_request(cbba_pkg::MODE_RELEASE, 10'd0,    11'd1024);
        wait_drained();
    endtask

    // block count register corners: small, back to reset value, zero, saturated
    task automatic test_block_count_limits();
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd10);
        wait_drained();
        write_block_count(11'd4);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd1);        // all managed blocks in use
        send_request(cbba_pkg::MODE_RELEASE, 10'd0, 11'd10);       // only the managed part clears
        wait_drained();
        write_block_count(11'd1024);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd5);        // hole below is too short
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd4);
        wait_drained();
        write_block_count(11'd0);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd1);        // nothing managed
        send_request(cbba_pkg::MODE_RELEASE, 10'd0, 11'd1024);     // changes nothing
        wait_drained();
        write_block_count(11'd2047);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd1);
        send_request(cbba_pkg::MODE_RELEASE, 10'd0, 11'd1024);
        send_request(cbba_pkg::MODE_ALLOC,   10'd0, 11'd1024);     // saturated count still fits
        send_request(cbba_pkg::MODE_RELEASE, 10'd0, 11'd1024);
        wait_drained();
    endtask

    // random traffic over a series of block count settings
    task automatic test_random_traffic();
        logic [cbba_pkg::CFG_W-1:0] settings [7];
        int                         per_phase [7];
        int p;
        int n;
        settings  = '{11'd1024, 11'd64, 11'd1, 11'd333, 11'd16, 11'd2047, 11'd700};
        per_phase = '{200, 150, 40, 150, 100, 150, 120};
        for (p = 0; p < 7; p++) begin
            write_block_count(settings[p]);
            for (n = 0; n < per_phase[p]; n++) random_request();
            wait_drained();
        end
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_result_holdoff();
        int n;
        hold_trig++;
        for (n = 0; n < 20; n++) random_request();
        // sender pauses here until every result is back
        wait_drained();
    endtask

    // no gaps on either side for a while
    task automatic test_back_to_back();
        int n;
        write_block_count(11'd256);
        sender_gaps  = 1'b0;
        steady_ready = 1'b1;
        for (n = 0; n < 100; n++) random_request();
        wait_drained();
        sender_gaps  = 1'b1;
        steady_ready = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_requests();
        test_block_count_limits();
        test_random_traffic();
        test_result_holdoff();
        test_back_to_back();

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cbba_pkg.sv
rtl/core/cbba_ram.sv
rtl/core/cbba_ctrl.sv
rtl/core/cbba_dpath.sv
rtl/core/contiguous_block_bitmap_allocator.sv
tb/tb_contiguous_block_bitmap_allocator.sv
